// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level of the mosaic block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bam_pkg.sv -----
// Types, widths and codes shared by the mosaic block modules.
package bam_pkg;

   // Field widths
   localparam int COL_W = 10;
   localparam int PIX_W = 8;
   localparam int CFG_W = 7;
   localparam int SUM_W = 20;
   localparam int CNT_W = 13;
   localparam int FUNC_W = 2;

   // Default sizes
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_BLOCK_DEF = 64;

   // Reset value of the block size register
   localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 7'd8;

   // Operation codes carried in the request tuser
   localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // One accumulator entry per block column
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } acc_entry_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COLDIV,
      ST_READ,
      ST_USE,
      ST_AVG,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_item;
      logic clr_init;
      logic clr_wr;
      logic ram_rd;
      logic acc_wr;
      logic avg_start;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              col_valid;
      logic              col_done;
      logic              avg_done;
      logic              clr_last;
      logic              rsp_free;
   } status_type;

endpackage

// ----- hw/rtl/bam_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bam_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module bam_div #(
   parameter int NW = 20,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
   end

   // Advance the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- hw/rtl/bam_datapath.sv -----
// Datapath: item registers, block column divider, accumulator RAM, averaging
// dividers and the result register.
module bam_datapath #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_BLOCK = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bam_pkg::cmd_type             cmd,
   output bam_pkg::status_type          stat,
   input  logic [bam_pkg::FUNC_W-1:0]   req_func,
   input  logic [bam_pkg::COL_W-1:0]    req_column,
   input  logic [bam_pkg::PIX_W-1:0]    req_red,
   input  logic [bam_pkg::PIX_W-1:0]    req_green,
   input  logic [bam_pkg::PIX_W-1:0]    req_blue,
   input  logic                         csr_we,
   input  logic [bam_pkg::CFG_W-1:0]    csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [3*bam_pkg::PIX_W-1:0]  rsp_data
);
   import bam_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [CFG_W-1:0]    block_size_ff;
   logic [CFG_W-1:0]    eff_size;
   logic [FUNC_W-1:0]   func_ff;
   logic                col_valid_ff;
   logic [PIX_W-1:0]    red_ff, green_ff, blue_ff;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                cnt_zero_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3*PIX_W-1:0]  rsp_data_ff;
   logic [COL_W-1:0]    col_quo;
   logic                col_done;
   logic [AW-1:0]       blk_addr;
   acc_entry_type       rd_entry;
   acc_entry_type       acc_next;
   acc_entry_type       wr_entry;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [SUM_W-1:0]    red_quo, green_quo, blue_quo;
   logic                red_done, green_done, blue_done;
   logic [SUM_W:0]      red_sum, green_sum, blue_sum;

   // Block size register
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
      end else if (csr_we) begin
         block_size_ff <= csr_wdata;
      end
   end

   // Clamp the block size to one at the bottom and the largest block at the top
   always_comb begin
      priority if (block_size_ff == '0) begin
         eff_size = CFG_W'(1);
      end else if (int'(block_size_ff) > MAX_BLOCK) begin
         eff_size = CFG_W'(MAX_BLOCK);
      end else begin
         eff_size = block_size_ff;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff      <= req_func;
         col_valid_ff <= (int'(req_column) < MAX_WIDTH);
         red_ff       <= req_red;
         green_ff     <= req_green;
         blue_ff      <= req_blue;
      end
   end

   // Block column = column / block size
   bam_div #(
      .NW (COL_W),
      .DW (CFG_W)
   ) u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load_item),
      .dividend (req_column),
      .divisor  (eff_size),
      .quotient (col_quo),
      .done     (col_done)
   );

   assign blk_addr = AW'(col_quo);

   // Clear sweep address
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_init) begin
         clr_addr_in = '0;
      end else if (cmd.clr_wr) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Saturating accumulate of the fetched entry
   always_comb begin
      red_sum   = {1'b0, rd_entry.red} + (SUM_W + 1)'(red_ff);
      green_sum = {1'b0, rd_entry.green} + (SUM_W + 1)'(green_ff);
      blue_sum  = {1'b0, rd_entry.blue} + (SUM_W + 1)'(blue_ff);
      acc_next.red   = red_sum[SUM_W] ? '1 : red_sum[SUM_W-1:0];
      acc_next.green = green_sum[SUM_W] ? '1 : green_sum[SUM_W-1:0];
      acc_next.blue  = blue_sum[SUM_W] ? '1 : blue_sum[SUM_W-1:0];
      acc_next.count = (&rd_entry.count) ? rd_entry.count : rd_entry.count + 1'b1;
   end

   // Select between the clear sweep and the accumulate write
   always_comb begin
      ram_we    = cmd.clr_wr | cmd.acc_wr;
      ram_waddr = cmd.clr_wr ? clr_addr_ff : blk_addr;
      wr_entry  = cmd.clr_wr ? '0 : acc_next;
   end

   bam_ram #(
      .WIDTH ($bits(acc_entry_type)),
      .DEPTH (MAX_WIDTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_entry),
      .rd_en   (cmd.ram_rd),
      .rd_addr (blk_addr),
      .rd_data (rd_entry)
   );

   // Per-channel averages, all three share the count
   bam_div #(.NW (SUM_W), .DW (CNT_W)) u_red_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.avg_start),
      .dividend (rd_entry.red),
      .divisor  (rd_entry.count),
      .quotient (red_quo),
      .done     (red_done)
   );

   bam_div #(.NW (SUM_W), .DW (CNT_W)) u_green_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.avg_start),
      .dividend (rd_entry.green),
      .divisor  (rd_entry.count),
      .quotient (green_quo),
      .done     (green_done)
   );

   bam_div #(.NW (SUM_W), .DW (CNT_W)) u_blue_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.avg_start),
      .dividend (rd_entry.blue),
      .divisor  (rd_entry.count),
      .quotient (blue_quo),
      .done     (blue_done)
   );

   // Remember an empty block
   always_ff @(posedge clock) begin
      if (cmd.avg_start) begin
         cnt_zero_ff <= (rd_entry.count == '0);
      end
   end

   // Result register: load the saturated averages (zero for an invalid column or an empty block), drop on handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (!col_valid_ff || cnt_zero_ff) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff[PIX_W-1:0] <=
               (|red_quo[SUM_W-1:PIX_W]) ? '1 : red_quo[PIX_W-1:0];
            rsp_data_ff[2*PIX_W-1:PIX_W] <=
               (|green_quo[SUM_W-1:PIX_W]) ? '1 : green_quo[PIX_W-1:0];
            rsp_data_ff[3*PIX_W-1:2*PIX_W] <=
               (|blue_quo[SUM_W-1:PIX_W]) ? '1 : blue_quo[PIX_W-1:0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status back to the controller
   always_comb begin
      stat.func      = func_ff;
      stat.col_valid = col_valid_ff;
      stat.col_done  = col_done;
      stat.avg_done  = red_done & green_done & blue_done;
      stat.clr_last  = (clr_addr_ff == AW'(MAX_WIDTH - 1));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

// ----- hw/rtl/bam_ctrl.sv -----
// Controller state machine sequencing clear, accumulate and read items.
module bam_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [bam_pkg::FUNC_W-1:0]  req_func,
   output logic                        req_ready,
   input  bam_pkg::status_type         stat,
   output bam_pkg::cmd_type            cmd
);
   import bam_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_CLEAR) ? ST_CLEAR : ST_COLDIV;
            end
         end
         ST_COLDIV: begin
            if (stat.col_done) begin
               priority if ((stat.func == FUNC_ACC || stat.func == FUNC_READ)
                            && stat.col_valid) begin
                  state_in = ST_READ;
               end else if (stat.func == FUNC_READ) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            state_in = (stat.func == FUNC_READ) ? ST_AVG : ST_IDLE;
         end
         ST_AVG: begin
            if (stat.avg_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load_item = (state_ff == ST_IDLE) && req_valid;
      cmd.clr_init  = (state_ff == ST_IDLE) && req_valid && (req_func == FUNC_CLEAR);
      cmd.clr_wr    = (state_ff == ST_CLEAR);
      cmd.ram_rd    = (state_ff == ST_READ);
      cmd.acc_wr    = (state_ff == ST_USE) && (stat.func == FUNC_ACC);
      cmd.avg_start = (state_ff == ST_USE) && (stat.func == FUNC_READ);
      cmd.rsp_load  = (state_ff == ST_OUT) && stat.rsp_free;
   end

endmodule

// ----- hw/rtl/block_average_mosaic.sv -----
// Mosaic block-average filter: top level joining controller and datapath.
//
// Request channel (req_*): one item per handshake; req_tuser carries the
// operation (accumulate, read average, clear band), req_tdata the column and
// the three color bytes. Accumulate adds the pixel to the sums of block
// column = column / block_size; read returns one result item with the
// truncated per-channel averages of that block column; clear empties all
// accumulators. Only read produces a result item on rsp_*.
// csr_we/csr_wdata write the block size; the user must write it only while
// the block is idle, the block itself does not enforce this. One item is
// handled at a time. The column divider and the averaging dividers produce
// one quotient bit per cycle. A read runs the column divide, the RAM read
// and the averaging divides, then loads the result register before the
// next item is taken; an accumulate runs the column divide plus the RAM
// read-modify-write; a clear writes one RAM entry per cycle. After reset
// the same clearing pass runs before req_tready rises; the block size returns to 8.
// A finished result waits in the output register; a stalled receiver holds
// the block only when the next read result is ready to be loaded.
`include "assert_macros.svh"

module block_average_mosaic #(
   parameter int MAX_WIDTH = bam_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BLOCK = bam_pkg::MAX_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: block size
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // column[9:0], red[17:10], green[25:18], blue[33:26]
   input  logic [1:0]  req_tuser,  // func[1:0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // red[7:0], green[15:8], blue[23:16]
);
   import bam_pkg::*;

   cmd_type    cmd;
   status_type stat;
   logic       req_fire;
   logic       clear_fire;
   logic       chan_quiet;

   bam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bam_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser),
      .req_column (req_tdata[COL_W-1:0]),
      .req_red    (req_tdata[COL_W+PIX_W-1:COL_W]),
      .req_green  (req_tdata[COL_W+2*PIX_W-1:COL_W+PIX_W]),
      .req_blue   (req_tdata[COL_W+3*PIX_W-1:COL_W+2*PIX_W]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

   // Handshake terms for the checks
   assign req_fire   = req_tvalid && req_tready;
   assign clear_fire = req_fire && (req_tuser == FUNC_CLEAR);
   assign chan_quiet = !req_tready && !rsp_tvalid;

   // Checks
   `ASSERT_NEXT(a_one_item, clock, reset, req_fire, !req_tready, "item accepted while busy")
   `ASSERT_NEXT(a_clear_busy, clock, reset, clear_fire, !req_tready, "clear left input open")
   `ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, chan_quiet, "no clear pass after reset")

endmodule

// ----- tb/sv/mosaic_average_checker.sv -----
// Checker for the mosaic filter: tracks block-column sums and checks every read average.
module mosaic_average_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [bam_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [39:0]                req_tdata,  // column[9:0], red[17:10], green[25:18], blue[33:26]
   input  logic [bam_pkg::FUNC_W-1:0] req_tuser,  // func[1:0]
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [23:0]                rsp_tdata,  // red[7:0], green[15:8], blue[23:16]
   output int                         mismatch_count,
   output int                         awaited_count
);
   import bam_pkg::*;

   localparam int SUM_LIMIT = (1 << SUM_W) - 1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_type;

   // Per block column sums and pixel counts
   logic [SUM_W-1:0] red_sum     [MAX_WIDTH_DEF];
   logic [SUM_W-1:0] green_sum   [MAX_WIDTH_DEF];
   logic [SUM_W-1:0] blue_sum    [MAX_WIDTH_DEF];
   logic [CNT_W-1:0] pixel_count [MAX_WIDTH_DEF];
   logic [CFG_W-1:0] block_size;

   // Averages owed to the result channel, oldest first
   rgb_type due_averages[$];
   rgb_type want_avg;

   function automatic void clear_sums();
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         red_sum[i] = '0;
         green_sum[i] = '0;
         blue_sum[i] = '0;
         pixel_count[i] = '0;
      end
   endfunction

   // Add one color byte, holding at the top of the sum range
   function automatic logic [SUM_W-1:0] add_capped(logic [SUM_W-1:0] sum, logic [PIX_W-1:0] v);
      int t;
      t = int'(sum) + int'(v);
      return (t > SUM_LIMIT) ? '1 : t[SUM_W-1:0];
   endfunction

   // Truncated mean; an empty block reads as zero
   function automatic logic [PIX_W-1:0] channel_mean(logic [SUM_W-1:0] sum,
                                                     logic [CNT_W-1:0] n);
      int q;
      if (n == '0) return '0;
      q = int'(sum) / int'(n);
      return (q > 255) ? '1 : q[PIX_W-1:0];
   endfunction

   function automatic void apply_pixel_item(logic [FUNC_W-1:0] op, logic [COL_W-1:0] col,
                                            logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                                            logic [PIX_W-1:0] blue);
      int span;
      int blk;
      rgb_type avg;
      span = int'(block_size);
      if (span == 0) span = 1;
      if (span > MAX_BLOCK_DEF) span = MAX_BLOCK_DEF;
      // a 10-bit column always lands inside the table
      blk = int'(col) / span;
      case (op)
         FUNC_CLEAR: clear_sums();
         FUNC_ACC: begin
            red_sum[blk] = add_capped(red_sum[blk], red);
            green_sum[blk] = add_capped(green_sum[blk], green);
            blue_sum[blk] = add_capped(blue_sum[blk], blue);
            if (pixel_count[blk] != '1) pixel_count[blk] = pixel_count[blk] + 1'b1;
         end
         FUNC_READ: begin
            avg.red = channel_mean(red_sum[blk], pixel_count[blk]);
            avg.green = channel_mean(green_sum[blk], pixel_count[blk]);
            avg.blue = channel_mean(blue_sum[blk], pixel_count[blk]);
            due_averages.push_back(avg);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_channel(string name, logic [PIX_W-1:0] want,
                                         logic [PIX_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Track configuration and items, retire results against the oldest average
   always @(posedge clock) begin
      if (reset) begin
         clear_sums();
         block_size = BLOCK_SIZE_RESET;
         due_averages.delete();
         awaited_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_averages.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result item: %h", rsp_tdata);
            end else begin
               want_avg = due_averages.pop_front();
               check_channel("red", want_avg.red, rsp_tdata[7:0]);
               check_channel("green", want_avg.green, rsp_tdata[15:8]);
               check_channel("blue", want_avg.blue, rsp_tdata[23:16]);
            end
         end
         if (csr_we) block_size = csr_wdata;
         if (req_tvalid && req_tready)
            apply_pixel_item(req_tuser, req_tdata[9:0], req_tdata[17:10], req_tdata[25:18],
                             req_tdata[33:26]);
         awaited_count <= due_averages.size();
      end
   end

endmodule

// ----- tb/sv/block_average_mosaic_test.sv -----
// Top of the mosaic filter testbench: clock, reset, stimulus, receiver pacing and verdict.
module block_average_mosaic_test;
   import bam_pkg::*;

   // Unused operation code, fed as noise
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int RUN_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 1200;
   localparam int LONG_HOLD = 600;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASE_COUNT = 8;
   localparam int SAT_PIXELS = 200;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CFG_W-1:0]  csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;  // column[9:0], red[17:10], green[25:18], blue[33:26]
   logic [FUNC_W-1:0] req_tuser = '0;  // func[1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;       // red[7:0], green[15:8], blue[23:16]
   logic              hold_req = 1'b0;

   int mismatch_count;
   int awaited_count;
   int cycle_count = 0;
   int burst_left = 0;
   int items_sent = 0;

   logic [CFG_W-1:0] phase_sizes [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd5};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   block_average_mosaic uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mosaic_average_checker watch (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Pace the result channel; honor one long hold-off when asked
   initial begin
      ready_mode_type mode;
      int mode_left;
      int hold_left;
      int tick;
      bit hold_done;
      mode = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:      rsp_tready <= (tick % 5 != 0);
            endcase
         end
      end
   end

   function automatic logic [PIX_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Open a new burst with a random gap in front of it when the last one ran out
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Offer one item and hold it until accepted
   task automatic send_item(input logic [FUNC_W-1:0] op, input logic [COL_W-1:0] col,
                            input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                            input logic [PIX_W-1:0] blue);
      pace();
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, blue, green, red, col};
      do @(posedge clock); while (!req_tready);
      if (op != FUNC_SPARE) items_sent++;
   endtask

   // Drop valid, wait for every owed average, then let a trailing clear finish
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_block_size(input logic [CFG_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One band: usually a clear, pixels over a window of columns, then reads
   task automatic run_band(input int span, input bit long_read_run);
      int width;
      int base;
      int n_acc;
      int n_read;
      if ($urandom_range(0, 7) != 0)
         send_item(FUNC_CLEAR, COL_W'($urandom), rand_byte(), rand_byte(), rand_byte());
      width = ($urandom_range(0, 5) == 0) ? MAX_WIDTH_DEF : $urandom_range(1, 4 * span);
      if (width > MAX_WIDTH_DEF) width = MAX_WIDTH_DEF;
      base = $urandom_range(0, MAX_WIDTH_DEF - width);
      n_acc = $urandom_range(3, 40);
      for (int i = 0; i < n_acc; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(FUNC_SPARE, COL_W'($urandom), rand_byte(), rand_byte(), rand_byte());
         else if ($urandom_range(0, 15) == 0)
            send_item(FUNC_READ, COL_W'(base + $urandom_range(0, width - 1)),
                      rand_byte(), rand_byte(), rand_byte());
         else
            send_item(FUNC_ACC, COL_W'(base + $urandom_range(0, width - 1)),
                      rand_byte(), rand_byte(), rand_byte());
      end
      n_read = long_read_run ? 12 : $urandom_range(2, 10);
      if (long_read_run) hold_req <= 1'b1;
      for (int i = 0; i < n_read; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(FUNC_READ, COL_W'($urandom), rand_byte(), rand_byte(), rand_byte());
         else
            send_item(FUNC_READ, COL_W'(base + $urandom_range(0, width - 1)),
                      rand_byte(), rand_byte(), rand_byte());
      end
   endtask

   initial begin
      logic [CFG_W-1:0] size;
      int span;
      bit first_band;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset block size of 8
      send_item(FUNC_READ, 10'd0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_ACC, 10'd0, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_ACC, 10'd7, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_ACC, 10'd5, 8'hFF, 8'h00, 8'h80);
      send_item(FUNC_READ, 10'd3, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_ACC, 10'd1023, 8'hAA, 8'h55, 8'hFF);
      send_item(FUNC_READ, 10'd1016, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_SPARE, 10'd1023, 8'hFF, 8'hFF, 8'hFF);
      send_item(FUNC_READ, 10'd1023, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_ACC, 10'd8, 8'h01, 8'h02, 8'h03);
      send_item(FUNC_ACC, 10'd15, 8'h02, 8'h03, 8'h04);
      send_item(FUNC_READ, 10'd15, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_ACC, 10'd512, 8'h55, 8'hAA, 8'h55);
      send_item(FUNC_READ, 10'd519, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_READ, 10'd520, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_READ, 10'd0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_READ, 10'd1023, 8'h00, 8'h00, 8'h00);
      settle();

      // Random bands under a sweep of block sizes, extremes first
      for (int p = 0; p < PHASE_COUNT; p++) begin
         size = (p < 6) ? phase_sizes[p] : CFG_W'($urandom_range(0, 127));
         set_block_size(size);
         span = int'(size);
         if (span == 0) span = 1;
         if (span > MAX_BLOCK_DEF) span = MAX_BLOCK_DEF;
         first_band = 1'b1;
         while (items_sent < 20 + (p + 1) * PHASE_ITEMS) begin
            run_band(span, first_band && p == 1);
            first_band = 1'b0;
         end
         settle();
      end

      // Pile full-scale pixels into the first block column; 100 acts as 64
      set_block_size(7'd100);
      send_item(FUNC_CLEAR, 10'd0, 8'h00, 8'h00, 8'h00);
      for (int i = 0; i < SAT_PIXELS; i++) begin
         send_item(FUNC_ACC, COL_W'($urandom_range(0, 63)), 8'hFF, 8'hFF, 8'hFF);
         if (i % 50 == 49)
            send_item(FUNC_READ, COL_W'($urandom_range(0, 63)), rand_byte(), rand_byte(),
                      rand_byte());
      end
      send_item(FUNC_READ, 10'd0, 8'h00, 8'h00, 8'h00);
      send_item(FUNC_READ, 10'd64, 8'h00, 8'h00, 8'h00);
      settle();

      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bam_pkg.sv
hw/rtl/bam_ram.sv
hw/rtl/bam_div.sv
hw/rtl/bam_datapath.sv
hw/rtl/bam_ctrl.sv
hw/rtl/block_average_mosaic.sv
tb/sv/mosaic_average_checker.sv
tb/sv/block_average_mosaic_test.sv
